// ===== rtl/core/dpt_pkg.sv =====
// Shared types and constants for the demand paging translator.
package dpt_pkg;

    localparam int MAX_PAGES  = 64;
    localparam int MAX_FRAMES = 16;
    localparam int ADDR_BITS  = 32;
    localparam int PG_W       = $clog2(MAX_PAGES);
    localparam int FR_W       = $clog2(MAX_FRAMES);
    localparam int FCNT_W     = FR_W + 1;
    localparam int MAX_PB     = 16;

    localparam logic [1:0] POL_FIFO  = 2'd0;
    localparam logic [1:0] POL_LRU   = 2'd1;
    localparam logic [1:0] POL_CLOCK = 2'd2;
    localparam logic [1:0] POL_NONE  = 2'd3;

    localparam logic [1:0] RES_HIT   = 2'd0;
    localparam logic [1:0] RES_FAULT = 2'd1;
    localparam logic [1:0] RES_OOR   = 2'd2;
    localparam logic [1:0] RES_FAIL  = 2'd3;

    localparam logic [1:0] REG_PAGE_BITS = 2'd0;
    localparam logic [1:0] REG_VPAGES    = 2'd1;
    localparam logic [1:0] REG_FRAMES    = 2'd2;
    localparam logic [1:0] REG_POLICY    = 2'd3;

    typedef struct packed {
        logic [4:0] pb;
        logic [6:0] vp;
        logic [4:0] nf;
        logic [1:0] policy;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_ACCEPT, OP_DECODE, OP_HIT, OP_FREE, OP_FIFO, OP_FIFO_RD,
        OP_LRU_RD, OP_LRU_CMP, OP_CLOCK, OP_LOAD, OP_FAIL
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_HITRD, S_FREE, S_FIFO, S_FIFORD, S_LRU_RD,
        S_LRU_CMP, S_CLOCK, S_LOAD, S_FAIL, S_OUT
    } state_t;

    typedef struct packed {
        op_t  op;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic       oor;
        logic       present;
        logic       free_found;
        logic       no_frames;
        logic       fifo_empty;
        logic       fifo_ok;
        logic       lru_done;
        logic       lru_found;
        logic       clock_hit;
        logic       clock_fail;
        logic       out_free;
        logic [1:0] policy;
    } sts_t;

endpackage

// ===== rtl/core/dpt_ctrl.sv =====
// Sequencing state machine for translation, fault handling and replacement.
module dpt_ctrl import dpt_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                priority if (sts.oor) state_next = S_OUT;
                else if (sts.present) state_next = S_HITRD;
                else state_next = S_FREE;
            end
            S_HITRD: state_next = S_OUT;
            S_FREE: begin
                priority if (sts.free_found) state_next = S_LOAD;
                else if (sts.no_frames) state_next = S_FAIL;
                else begin
                    unique case (sts.policy)
                        POL_FIFO:  state_next = sts.fifo_empty ? S_FAIL : S_FIFO;
                        POL_LRU:   state_next = S_LRU_RD;
                        POL_CLOCK: state_next = S_CLOCK;
                        default:   state_next = S_FAIL;
                    endcase
                end
            end
            S_FIFO: state_next = sts.fifo_ok ? S_FIFORD : S_FAIL;
            S_FIFORD: state_next = S_LOAD;
            S_LRU_RD: state_next = S_LRU_CMP;
            S_LRU_CMP: begin
                if (sts.lru_done) state_next = sts.lru_found ? S_LOAD : S_FAIL;
                else state_next = S_LRU_RD;
            end
            S_CLOCK: begin
                priority if (sts.clock_hit) state_next = S_LOAD;
                else if (sts.clock_fail) state_next = S_FAIL;
                else state_next = S_CLOCK;
            end
            S_LOAD: state_next = S_OUT;
            S_FAIL: state_next = S_OUT;
            S_OUT: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = OP_ACCEPT;
            end
            S_DECODE:  cmd.op = OP_DECODE;
            S_HITRD:   cmd.op = OP_HIT;
            S_FREE:    cmd.op = OP_FREE;
            S_FIFO:    cmd.op = OP_FIFO;
            S_FIFORD:  cmd.op = OP_FIFO_RD;
            S_LRU_RD:  cmd.op = OP_LRU_RD;
            S_LRU_CMP: cmd.op = OP_LRU_CMP;
            S_CLOCK:   cmd.op = OP_CLOCK;
            S_LOAD:    cmd.op = OP_LOAD;
            S_FAIL:    cmd.op = OP_FAIL;
            S_OUT:     cmd.out_load = sts.out_free;
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/core/dpt_datapath.sv =====
// Page tables, frame tables, replacement state, counters and result register.
module dpt_datapath import dpt_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          clear,
    input  cfg_t          cfg,
    input  cmd_t          cmd,
    output sts_t          sts,
    input  logic [31:0]   s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata
);

    logic [MAX_PAGES-1:0]  present_reg;
    logic [MAX_PAGES-1:0]  ref_reg;
    logic [MAX_FRAMES-1:0] used_reg;
    logic [PG_W-1:0]       owner_reg [MAX_FRAMES];
    logic [PG_W-1:0]       fifo_reg [MAX_FRAMES];
    logic [FR_W-1:0]       pf_mem [MAX_PAGES];
    logic [31:0]           lu_mem [MAX_PAGES];
    logic [FR_W-1:0]       pf_q_reg;
    logic [31:0]           lu_q_reg;

    logic [FR_W-1:0]   head_reg;
    logic [FCNT_W-1:0] count_reg;
    logic [FR_W-1:0]   sp_reg;
    logic              wraps_reg;
    logic [FR_W-1:0]   scan_reg;
    logic              found_reg;
    logic [31:0]       best_reg;
    logic [31:0]       use_reg;
    logic [31:0]       hits_reg;
    logic [31:0]       faults_reg;

    logic [31:0]     va_reg;
    logic [PG_W-1:0] pg_reg;
    logic [FR_W-1:0] frame_reg;
    logic            ev_reg;
    logic [PG_W-1:0] evpage_reg;
    logic [1:0]      res_reg;
    logic            m_tvalid_reg;
    logic [111:0]    m_tdata_reg;

    logic [31:0]     pg32;
    logic [31:0]     off;
    logic [PG_W-1:0] pg_cur;
    logic [FR_W-1:0] idx;
    logic [PG_W-1:0] own_idx;
    logic [PG_W-1:0] fifo_pg;
    logic [PG_W-1:0] rd_addr;
    logic [PG_W-1:0] wr_addr;
    logic            free_found;
    logic [FR_W-1:0] free_idx;
    logic            lru_take;
    logic [FR_W-1:0] sp_step;
    logic [31:0]     paddr;

    assign pg32   = (va_reg & 32'((64'd1 << ADDR_BITS) - 64'd1)) >> cfg.pb;
    assign off    = va_reg & ((32'd1 << cfg.pb) - 32'd1);
    assign pg_cur = pg32[PG_W-1:0];
    assign fifo_pg = fifo_reg[head_reg];

    always_comb begin
        unique case (cmd.op)
            OP_LRU_RD, OP_LRU_CMP: idx = scan_reg;
            OP_CLOCK:              idx = sp_reg;
            default:               idx = frame_reg;
        endcase
    end
    assign own_idx = owner_reg[idx];

    always_comb begin
        unique case (cmd.op)
            OP_FIFO:   rd_addr = fifo_pg;
            OP_LRU_RD: rd_addr = own_idx;
            default:   rd_addr = pg_cur;
        endcase
    end
    assign wr_addr = (cmd.op == OP_LOAD) ? pg_reg : pg_cur;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (!used_reg[i] && (FCNT_W'(i) < cfg.nf)) begin
                free_found = 1'b1;
                free_idx   = FR_W'(i);
            end
        end
    end

    assign lru_take = used_reg[scan_reg] && (!found_reg || lu_q_reg < best_reg);
    assign sp_step  = ((FCNT_W'(sp_reg) + FCNT_W'(1)) == cfg.nf) ? '0 : sp_reg + FR_W'(1);
    assign paddr    = (32'(frame_reg) << cfg.pb) + off;

    always_comb begin
        sts.oor        = pg32 >= 32'(cfg.vp);
        sts.present    = present_reg[pg_cur];
        sts.free_found = free_found;
        sts.no_frames  = cfg.nf == '0;
        sts.fifo_empty = count_reg == '0;
        sts.fifo_ok    = present_reg[fifo_pg];
        sts.lru_done   = (FCNT_W'(scan_reg) + FCNT_W'(1)) == cfg.nf;
        sts.lru_found  = found_reg || lru_take;
        sts.clock_hit  = used_reg[sp_reg] && !ref_reg[own_idx];
        sts.clock_fail = (sp_step == '0) && wraps_reg;
        sts.out_free   = !m_tvalid_reg || m_tready;
        sts.policy     = cfg.policy;
    end

    // Tables in block storage
    always_ff @(posedge aclk) begin
        pf_q_reg <= pf_mem[rd_addr];
        lu_q_reg <= lu_mem[rd_addr];
        if (cmd.op == OP_LOAD) begin
            pf_mem[wr_addr] <= frame_reg;
        end
        if (cmd.op == OP_LOAD || (cmd.op == OP_DECODE && !sts.oor && sts.present)) begin
            lu_mem[wr_addr] <= use_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            owner_reg[frame_reg] <= pg_reg;
            if (cfg.policy == POL_FIFO && count_reg < FCNT_W'(MAX_FRAMES)) begin
                fifo_reg[head_reg + count_reg[FR_W-1:0]] <= pg_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_ACCEPT: va_reg <= s_tdata;
            OP_DECODE: begin
                pg_reg     <= pg_cur;
                ev_reg     <= 1'b0;
                evpage_reg <= '0;
                res_reg    <= sts.oor ? RES_OOR : RES_HIT;
            end
            OP_HIT: frame_reg <= pf_q_reg;
            OP_FREE: begin
                frame_reg <= free_idx;
                scan_reg  <= '0;
                found_reg <= 1'b0;
            end
            OP_FIFO_RD: begin
                frame_reg <= pf_q_reg;
                ev_reg    <= 1'b1;
            end
            OP_LRU_CMP: begin
                if (lru_take) begin
                    best_reg  <= lu_q_reg;
                    frame_reg <= scan_reg;
                end
                found_reg <= found_reg || lru_take;
                scan_reg  <= scan_reg + FR_W'(1);
                ev_reg    <= 1'b1;
            end
            OP_CLOCK: begin
                if (sts.clock_hit) begin
                    frame_reg <= sp_reg;
                    ev_reg    <= 1'b1;
                end
            end
            OP_LOAD: begin
                res_reg <= RES_FAULT;
                if (ev_reg) evpage_reg <= own_idx;
            end
            OP_FAIL: begin
                res_reg <= RES_FAIL;
                ev_reg  <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            present_reg <= '0;
            ref_reg     <= '0;
            used_reg    <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
            sp_reg      <= '0;
            wraps_reg   <= 1'b0;
            use_reg     <= '0;
            hits_reg    <= '0;
            faults_reg  <= '0;
        end else begin
            unique case (cmd.op)
                OP_ACCEPT: use_reg <= use_reg + 32'd1;
                OP_DECODE: begin
                    if (!sts.oor && sts.present) begin
                        hits_reg        <= hits_reg + 32'd1;
                        ref_reg[pg_cur] <= 1'b1;
                    end else if (!sts.oor) begin
                        faults_reg <= faults_reg + 32'd1;
                    end
                end
                OP_FREE: begin
                    wraps_reg <= 1'b0;
                    if (!free_found && cfg.nf != '0 && cfg.policy == POL_CLOCK
                        && FCNT_W'(sp_reg) >= cfg.nf) begin
                        sp_reg <= '0;
                    end
                end
                OP_FIFO: begin
                    head_reg  <= head_reg + FR_W'(1);
                    count_reg <= count_reg - FCNT_W'(1);
                end
                OP_CLOCK: begin
                    sp_reg <= sp_step;
                    if (!sts.clock_hit) begin
                        if (used_reg[sp_reg]) ref_reg[own_idx] <= 1'b0;
                        if (sp_step == '0) wraps_reg <= 1'b1;
                    end
                end
                OP_LOAD: begin
                    if (ev_reg) present_reg[own_idx] <= 1'b0;
                    present_reg[pg_reg] <= 1'b1;
                    ref_reg[pg_reg]     <= 1'b1;
                    used_reg[frame_reg] <= 1'b1;
                    if (cfg.policy == POL_FIFO && count_reg < FCNT_W'(MAX_FRAMES)) begin
                        count_reg <= count_reg + FCNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {7'd0, faults_reg, hits_reg, evpage_reg, ev_reg,
                            (res_reg == RES_HIT || res_reg == RES_FAULT) ? paddr : 32'd0,
                            res_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_fifo_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FCNT_W'(MAX_FRAMES))
        else $error("fifo count overflow");
    a_load_present: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_LOAD && !clear |=> present_reg[$past(pg_reg)] && used_reg[$past(frame_reg)])
        else $error("loaded page not resident");
    a_sweep_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_CLOCK && !clear |=> FCNT_W'(sp_reg) < cfg.nf)
        else $error("sweep pointer out of range");

endmodule

// ===== rtl/core/demand_paging_translator.sv =====
// Top level of the demand paging translator: config registers, control and datapath.
//
// Input channel s_*: one transaction carries a 32-bit virtual address in s_tdata.
// Output channel m_*: one result per input, 112-bit m_tdata (fields below).
// APB port: registers page_bits, virtual_pages, frames_in_use, policy at byte
// addresses 0x0, 0x4, 0x8, 0xC. Any register write clears page tables, frame
// tables, replacement pointers and all counters; write only when idle.
// One address is handled at a time. An out-of-range address goes from decode
// straight to the result; a hit reads the frame table; a fault takes a free frame
// and loads it, or fails when there is no way to resolve it. A FIFO eviction pops
// the queue and reads the popped page's frame (it fails when that page is gone),
// an LRU eviction reads and compares the use-time table for each frame in use, a
// CLOCK eviction visits the frames in use one by one, up to two turns. The next
// address is accepted in the cycle after the result is registered.
// The result sits in an output register; the next address is taken while it
// waits, but the following result is held until m_tready drains the register.
// Reset (aresetn low, synchronous) restores the default configuration and
// clears all tables and counters.
module demand_paging_translator import dpt_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // vaddr[31:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], paddr[33:2], evicted[34], evicted_page[40:35],
    // hit_count[72:41], fault_count[104:73], zero[111:105]
    output logic [111:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [4:0] page_bits_reg;
    logic [6:0] vpages_reg;
    logic [4:0] frames_reg;
    logic [1:0] policy_reg;
    logic       wr_en;
    cfg_t       cfg;
    cmd_t       cmd;
    sts_t       sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_bits_reg <= 5'd12;
            vpages_reg    <= 7'd64;
            frames_reg    <= 5'd16;
            policy_reg    <= POL_FIFO;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_PAGE_BITS: page_bits_reg <= pwdata[4:0];
                REG_VPAGES:    vpages_reg    <= pwdata[6:0];
                REG_FRAMES:    frames_reg    <= pwdata[4:0];
                REG_POLICY:    policy_reg    <= pwdata[1:0];
                default:       policy_reg    <= policy_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PAGE_BITS: prdata = {27'd0, page_bits_reg};
            REG_VPAGES:    prdata = {25'd0, vpages_reg};
            REG_FRAMES:    prdata = {27'd0, frames_reg};
            REG_POLICY:    prdata = {30'd0, policy_reg};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        cfg.pb     = (page_bits_reg > 5'(MAX_PB)) ? 5'(MAX_PB) : page_bits_reg;
        cfg.vp     = (vpages_reg > 7'(MAX_PAGES)) ? 7'(MAX_PAGES) : vpages_reg;
        cfg.nf     = (frames_reg > 5'(MAX_FRAMES)) ? 5'(MAX_FRAMES) : frames_reg;
        cfg.policy = policy_reg;
    end

    dpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dpt_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (wr_en),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== bench/tb_demand_paging_translator.sv =====
// Self-checking testbench for the demand paging translator: predicts every translation result.
module tb_demand_paging_translator;
    import dpt_pkg::*;

    typedef struct packed {
        logic [31:0] fault_count;
        logic [31:0] hit_count;
        logic [5:0]  evicted_page;
        logic        evicted;
        logic [31:0] paddr;
        logic [1:0]  status;
    } xlat_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [31:0]  s_tdata = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [111:0] m_tdata;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [3:0]   paddr = 0;
    logic [31:0]  pwdata = 0;
    logic [31:0]  prdata;
    logic         pready;

    demand_paging_translator dut (.*);

    always #2 aclk = ~aclk;

    // predictor state
    logic [4:0]  cfg_pb;
    logic [6:0]  cfg_vp;
    logic [4:0]  cfg_nf;
    logic [1:0]  cfg_pol;
    logic        pg_present [MAX_PAGES];
    logic [3:0]  pg_frame [MAX_PAGES];
    logic [31:0] pg_last [MAX_PAGES];
    logic        pg_ref [MAX_PAGES];
    logic        fr_used [MAX_FRAMES];
    logic [5:0]  fr_owner [MAX_FRAMES];
    logic [5:0]  fifo_q [MAX_FRAMES];
    logic [3:0]  fifo_hd;
    logic [4:0]  fifo_cnt;
    logic [3:0]  sweep;
    logic [31:0] use_ctr, hit_ctr, fault_ctr;

    xlat_t expected_xlats [$];
    int    errors = 0;
    bit    idle_en = 1;

    task automatic clear_tables();
        for (int i = 0; i < MAX_PAGES; i++) begin
            pg_present[i] = 0; pg_frame[i] = 0; pg_last[i] = 0; pg_ref[i] = 0;
        end
        for (int i = 0; i < MAX_FRAMES; i++) begin
            fr_used[i] = 0; fr_owner[i] = 0; fifo_q[i] = 0;
        end
        fifo_hd = 0; fifo_cnt = 0; sweep = 0;
        use_ctr = 0; hit_ctr = 0; fault_ctr = 0;
    endtask

    function automatic bit pick_victim(int nf, output int fr);
        int pg, wraps, sp;
        logic [31:0] best;
        bit found;
        fr = 0;
        if (nf == 0) return 0;
        case (cfg_pol)
            POL_FIFO: begin
                if (fifo_cnt == 0) return 0;
                pg = int'(fifo_q[fifo_hd]);
                fifo_hd = fifo_hd + 4'd1;
                fifo_cnt = fifo_cnt - 5'd1;
                if (!pg_present[pg]) return 0;
                fr = int'(pg_frame[pg]);
                return 1;
            end
            POL_LRU: begin
                found = 0; best = 0;
                for (int i = 0; i < nf; i++)
                    if (fr_used[i] && (!found || pg_last[fr_owner[i]] < best)) begin
                        found = 1; best = pg_last[fr_owner[i]]; fr = i;
                    end
                return found;
            end
            POL_CLOCK: begin
                wraps = 0;
                sp = int'(sweep);
                if (sp >= nf) sp = 0;
                while (wraps < 2) begin
                    if (fr_used[sp]) begin
                        pg = int'(fr_owner[sp]);
                        if (pg_ref[pg]) pg_ref[pg] = 0;
                        else begin
                            fr = sp;
                            sweep = 4'((sp + 1) % nf);
                            return 1;
                        end
                    end
                    sp = (sp + 1) % nf;
                    if (sp == 0) wraps++;
                end
                sweep = 4'(sp);
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    function automatic xlat_t translate(logic [31:0] va);
        xlat_t r;
        int pb, vp, nf, fr, pg, victim;
        logic [31:0] vpn, off;
        bit got;
        pb = (cfg_pb > MAX_PB) ? MAX_PB : cfg_pb;
        vp = (cfg_vp > MAX_PAGES) ? MAX_PAGES : cfg_vp;
        nf = (cfg_nf > MAX_FRAMES) ? MAX_FRAMES : cfg_nf;
        vpn = va >> pb;
        off = va & ((32'd1 << pb) - 32'd1);
        r = '0;
        fr = 0;
        use_ctr++;
        if (vpn >= vp) r.status = RES_OOR;
        else begin
            pg = int'(vpn);
            if (pg_present[pg]) begin
                hit_ctr++;
                pg_last[pg] = use_ctr; pg_ref[pg] = 1;
                fr = int'(pg_frame[pg]);
                r.status = RES_HIT;
            end else begin
                got = 0;
                fault_ctr++;
                for (int i = 0; i < nf && !got; i++)
                    if (!fr_used[i]) begin fr = i; got = 1; end
                if (!got && pick_victim(nf, fr)) begin
                    victim = int'(fr_owner[fr]);
                    pg_present[victim] = 0;
                    fr_used[fr] = 0;
                    r.evicted = 1; r.evicted_page = 6'(victim);
                    got = 1;
                end
                if (got) begin
                    pg_present[pg] = 1; pg_frame[pg] = 4'(fr); pg_last[pg] = use_ctr;
                    pg_ref[pg] = 1; fr_used[fr] = 1; fr_owner[fr] = 6'(pg);
                    if (cfg_pol == POL_FIFO && fifo_cnt < MAX_FRAMES) begin
                        fifo_q[(int'(fifo_hd) + int'(fifo_cnt)) % MAX_FRAMES] = 6'(pg);
                        fifo_cnt++;
                    end
                    r.status = RES_FAULT;
                end else r.status = RES_FAIL;
            end
            if (r.status == RES_HIT || r.status == RES_FAULT)
                r.paddr = (32'(fr) << pb) + off;
        end
        r.hit_count = hit_ctr;
        r.fault_count = fault_ctr;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    task automatic random_idle();
        if (idle_en && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 13)) @(negedge aclk);
    endtask

    task automatic send_vaddr(logic [31:0] va);
        random_idle();
        s_tvalid <= 1;
        s_tdata <= va;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_xlats.insert(expected_xlats.size(), translate(va));
        @(negedge aclk);
        s_tvalid <= 0;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (expected_xlats.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_PAGE_BITS: cfg_pb = val[4:0];
            REG_VPAGES:    cfg_vp = val[6:0];
            REG_FRAMES:    cfg_nf = val[4:0];
            default:       cfg_pol = val[1:0];
        endcase
        clear_tables();
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(negedge aclk);
    endtask

    task automatic configure(int pb, int vp, int nf, int pol);
        drain();
        write_reg(REG_PAGE_BITS, pb);
        write_reg(REG_VPAGES, vp);
        write_reg(REG_FRAMES, nf);
        write_reg(REG_POLICY, pol);
    endtask

    // mostly in-range pages with random offsets, some fully random addresses
    task automatic send_page_mix(int n, int span);
        int pb;
        logic [31:0] off;
        pb = (cfg_pb > MAX_PB) ? MAX_PB : cfg_pb;
        for (int i = 0; i < n; i++) begin
            off = $urandom() & ((32'd1 << pb) - 32'd1);
            if ($urandom_range(0, 9) == 0) send_vaddr($urandom());
            else send_vaddr((32'($urandom_range(0, span)) << pb) | off);
        end
    endtask

    task automatic test_directed();
        send_vaddr(32'h0);
        send_vaddr(32'hFFFF_FFFF);
        send_vaddr(32'h0000_0FFF);
        send_vaddr(32'h0003_F123);
        send_vaddr(32'h0004_0000);
        send_vaddr(32'h0000_1000);
        send_vaddr(32'h0000_0800);
        configure(16, 64, 0, POL_FIFO);
        send_vaddr(32'h0000_0001);
        send_vaddr(32'h0001_0002);
        send_vaddr(32'hAAAA_5555);
        configure(31, 127, 31, POL_NONE);
        for (int i = 0; i < 8; i++) send_vaddr($urandom());
        configure(0, 0, 1, POL_LRU);
        send_vaddr(32'h0);
        send_vaddr(32'h5555_AAAA);
    endtask

    task automatic test_policy(int pol, int n);
        configure($urandom_range(0, 16), $urandom_range(4, 64), $urandom_range(1, 6), pol);
        send_page_mix(n, 12);
        configure(12, 64, 16, pol);
        send_page_mix(n, 40);
        configure($urandom_range(0, 20), $urandom_range(1, 127), $urandom_range(0, 31), pol);
        send_page_mix(n / 2, 70);
    endtask

    task automatic test_final_stream();
        idle_en = 0;
        configure(4, 16, 3, POL_CLOCK);
        send_page_mix(150, 20);
    endtask

    // result checker with random backpressure
    initial begin
        xlat_t got, want;
        forever begin
            @(negedge aclk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = m_tdata[104:0];
                if (expected_xlats.size() == 0) begin
                    report_mismatch("unexpected transaction", 32'd1, 32'd0);
                end else begin
                    want = expected_xlats[0];
                    expected_xlats.delete(0);
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.paddr != want.paddr)
                        report_mismatch("paddr", got.paddr, want.paddr);
                    if (got.evicted != want.evicted)
                        report_mismatch("evicted", got.evicted, want.evicted);
                    if (got.evicted_page != want.evicted_page)
                        report_mismatch("evicted_page", got.evicted_page, want.evicted_page);
                    if (got.hit_count != want.hit_count)
                        report_mismatch("hit_count", got.hit_count, want.hit_count);
                    if (got.fault_count != want.fault_count)
                        report_mismatch("fault_count", got.fault_count, want.fault_count);
                end
            end
        end
    end

    initial begin
        cfg_pb = 12; cfg_vp = 64; cfg_nf = 16; cfg_pol = POL_FIFO;
        clear_tables();
        repeat (7) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        test_directed();
        test_policy(POL_FIFO, 240);
        test_policy(POL_LRU, 240);
        test_policy(POL_CLOCK, 240);
        test_final_stream();
        drain();
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
